[rtl/lruc_pkg.sv]
`timescale 1ns / 1ps

package lruc_pkg;

  // Fixed field widths
  localparam int KeyW = 32;
  localparam int ValW = 32;
  localparam int CapW = 5;

  // Entry count: default and largest supported
  localparam int DefEntries = 16;
  localparam int MaxEntries = 64;

  // Rank and slot fields on the shared buses hold 0..MaxEntries
  localparam int CntW = $clog2(MaxEntries + 1);

  localparam logic [CapW-1:0] CapReset = CapW'(16);

  // Operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Kind of update broadcast to every cell
  typedef enum logic [1:0] {
    UPD_HIT,
    UPD_FILL,
    UPD_EVICT
  } upd_kind_e;

  // Lookup token travelling down the row of cells, one cell per cycle
  typedef struct packed {
    logic            vld;
    logic            op;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
    logic            found;
    logic [CntW-1:0] rank;
    logic [ValW-1:0] hit_value;
  } lruc_tok_t;

  // Update broadcast from the controller to all cells at the end of a search
  typedef struct packed {
    logic            apply;
    upd_kind_e       kind;
    logic [CntW-1:0] thr;
    logic [CntW-1:0] slot;
    logic            wr_value;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } lruc_upd_t;

endpackage

[rtl/lru_key_value_cache.sv]
`timescale 1ns / 1ps

// Fully associative key/value cache with least-recently-used replacement.
//
// Command channel: op_i, key_i, value_i are taken at a rising edge with start
// high and busy low. A get (op 0) returns one beat on hit_o / read_value_o,
// marked by strobe_o for a single cycle; a miss gives hit 0 and all ones.
// A put (op 1) updates or inserts and returns nothing.
// Config: cfg_we_i writes cfg_wdata_i into the capacity register; only write
// it while busy is low. Capacity 0 acts as 1, above ENTRIES as ENTRIES.
//
// Each command walks a lookup token down a row of ENTRIES cells, one cell a
// cycle, then one update cycle is broadcast to the row. busy rises at the
// accepting edge and falls when the token leaves the last cell; for a get,
// strobe_o rises in the cycle where busy has fallen. A new command is taken
// only once busy is low, so the length of the cell row sets the command rate.
// Reset clears all valid marks, ranks and the fill count, and sets capacity
// to 16. The receiver cannot stall: every result beat is taken as shown.

module lru_key_value_cache #(
  parameter int ENTRIES = lruc_pkg::DefEntries
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      op_i,
  input  logic signed [31:0]        key_i,
  input  logic signed [31:0]        value_i,
  output logic                      strobe_o,
  output logic                      hit_o,
  output logic signed [31:0]        read_value_o,
  input  logic                      cfg_we_i,
  input  logic [lruc_pkg::CapW-1:0] cfg_wdata_i
);
  import lruc_pkg::*;

  localparam int UW   = $clog2(ENTRIES + 1);
  localparam int CmpW = (UW > CapW) ? UW : CapW;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  logic            state_q, state_d;
  logic [CapW-1:0] cap_q;
  logic [UW-1:0]   used_q;
  logic            strobe_q;
  logic            hit_q;
  logic [ValW-1:0] rdata_q;

  lruc_tok_t tok [ENTRIES+1];
  lruc_tok_t tail;
  lruc_upd_t upd;

  logic            accept;
  logic [CmpW-1:0] cap_ext;
  logic [CmpW-1:0] eff_cap;
  logic            room;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q == ST_SEARCH);

  // Head of the row
  always_comb begin
    tok[0]           = '0;
    tok[0].vld       = accept;
    tok[0].op        = op_i;
    tok[0].key       = key_i;
    tok[0].value     = value_i;
    tok[0].found     = 1'b0;
  end

  // Row of cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lruc_cell #(
      .ENTRIES(ENTRIES),
      .IDX    (i)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (tok[i]),
      .tok_o (tok[i+1]),
      .upd_i (upd)
    );
  end

  assign tail = tok[ENTRIES];

  // Effective capacity and room for a new slot
  always_comb begin
    cap_ext = CmpW'(cap_q);
    if (cap_ext == '0) begin
      eff_cap = CmpW'(1);
    end else if (cap_ext > CmpW'(ENTRIES)) begin
      eff_cap = CmpW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    room = CmpW'(used_q) < eff_cap;
  end

  // Update broadcast when the token leaves the last cell
  always_comb begin
    upd          = '0;
    upd.apply    = tail.vld;
    upd.kind     = UPD_HIT;
    upd.key      = tail.key;
    upd.value    = tail.value;
    upd.slot     = CntW'(used_q);
    priority if (tail.found) begin
      upd.thr      = tail.rank;
      upd.wr_value = (tail.op == OP_PUT);
    end else if (tail.op == OP_PUT && room) begin
      upd.kind     = UPD_FILL;
      upd.thr      = CntW'(ENTRIES);
      upd.wr_value = 1'b1;
    end else if (tail.op == OP_PUT) begin
      upd.kind     = UPD_EVICT;
      upd.thr      = CntW'(used_q) - CntW'(1);
      upd.wr_value = 1'b1;
    end else begin
      // get miss: nothing ages
      upd.thr      = '0;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = ST_SEARCH;
      ST_SEARCH: if (tail.vld) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cap_q    <= CapReset;
      used_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= tail.vld && (tail.op == OP_GET);
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (upd.apply && upd.kind == UPD_FILL) begin
        used_q <= used_q + UW'(1);
      end
    end
  end

  // Result beat
  always_ff @(posedge clk_i) begin
    if (tail.vld) begin
      hit_q   <= tail.found;
      rdata_q <= tail.found ? tail.hit_value : '1;
    end
  end

  assign strobe_o     = strobe_q;
  assign hit_o        = hit_q;
  assign read_value_o = rdata_q;

`ifndef SYNTHESIS
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !busy)
    else $error("result beat while a search is still running");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy not raised after a command was taken");

  a_tail_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.vld |-> (state_q == ST_SEARCH))
    else $error("token left the row outside a search");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(used_q) <= CmpW'(ENTRIES))
    else $error("fill count beyond the entry count");
`endif

endmodule

[rtl/lruc_cell.sv]
`timescale 1ns / 1ps

module lruc_cell #(
  parameter int ENTRIES = 16,
  parameter int IDX     = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lruc_pkg::lruc_tok_t tok_i,
  output lruc_pkg::lruc_tok_t tok_o,
  input  lruc_pkg::lruc_upd_t upd_i
);
  import lruc_pkg::*;

  localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic            valid_q;
  logic [RW-1:0]   rank_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] value_q;
  logic            match_q;
  lruc_tok_t       tok_q, tok_d;

  logic match;
  logic age;
  logic sel;

  // Compare the passing token against this entry
  assign match = tok_i.vld && valid_q && (key_q == tok_i.key);

  always_comb begin
    tok_d = tok_i;
    if (match) begin
      tok_d.found     = 1'b1;
      tok_d.rank      = CntW'(rank_q);
      tok_d.hit_value = value_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

  // Entries more recent than the threshold age by one
  assign age = valid_q && (CntW'(rank_q) < upd_i.thr);

  // Which entry the update lands on
  always_comb begin
    unique case (upd_i.kind)
      UPD_HIT:   sel = match_q;
      UPD_FILL:  sel = (upd_i.slot == CntW'(IDX));
      UPD_EVICT: sel = valid_q && (CntW'(rank_q) == upd_i.thr);
      default:   sel = 1'b0;
    endcase
  end

  // Control state: valid, rank, match flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
      match_q <= 1'b0;
    end else if (upd_i.apply) begin
      match_q <= 1'b0;
      if (sel) begin
        valid_q <= 1'b1;
        rank_q  <= '0;
      end else if (age) begin
        rank_q <= rank_q + RW'(1);
      end
    end else if (match) begin
      match_q <= 1'b1;
    end
  end

  // Entry payload
  always_ff @(posedge clk_i) begin
    if (upd_i.apply && sel) begin
      if (upd_i.kind != UPD_HIT) begin
        key_q <= upd_i.key;
      end
      if (upd_i.wr_value) begin
        value_q <= upd_i.value;
      end
    end
  end

endmodule
